FILE: hw/rtl/sia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg: shared types and codes for the shell integer ALU
// Operation codes, error codes and the packed payload structs.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int unsigned DataWidthDef = 64;
  localparam int unsigned ShiftMask    = 63;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,  OP_POW  = 5'd5,  OP_SHL  = 5'd6,  OP_SHR  = 5'd7,
    OP_LT   = 5'd8,  OP_LE   = 5'd9,  OP_GT   = 5'd10, OP_GE   = 5'd11,
    OP_EQ   = 5'd12, OP_NE   = 5'd13, OP_AND  = 5'd14, OP_XOR  = 5'd15,
    OP_OR   = 5'd16, OP_LAND = 5'd17, OP_LOR  = 5'd18, OP_NEG  = 5'd19,
    OP_LNOT = 5'd20, OP_BNOT = 5'd21
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_DIV0    = 2'd1,
    ERR_NEG_EXP = 2'd2
  } err_t;

  typedef struct packed {
    logic [4:0]         command;
    logic signed [63:0] left_operand;
    logic signed [63:0] right_operand;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic [1:0]         error_code;
  } out_item_t;

endpackage

FILE: hw/rtl/sia_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_mul: multi-cycle wrapping multiplier
// Shift-and-add over one bit of the multiplier per cycle; low W bits kept.
// ----------------------------------------------------------------------------
module sia_mul #(
  parameter int unsigned W = sia_pkg::DataWidthDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] p
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt, mc_r, mc_nxt, ml_r, ml_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    ml_nxt   = ml_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = a;
      ml_nxt   = b;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // add the multiplicand once for each set bit, then advance
      if (ml_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt  = mc_r << 1;
      ml_nxt  = ml_r >> 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    ml_r  <= ml_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

FILE: hw/rtl/shell_integer_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_integer_alu: 64-bit signed ALU with shell arithmetic rules
// One operation per input transfer, one result plus error code per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry {command, left_operand, right_operand}; out_valid/
//   out_ready carry {result, error_code}. One item is worked at a time and
//   in_ready is low from the input transfer until the result transfers out.
//   Simple operations and error cases show out_valid in the cycle after the
//   input transfer. Multiply runs on the shared shift-and-add multiplier,
//   divide and modulo on the restoring divider (one quotient bit a cycle).
//   Power runs one multiplier pass per squaring and one per set exponent
//   bit: up to 2W-3 passes for the largest positive exponent; the
//   multiplier is the bottleneck.
//   When the receiver stalls the result is held in the output register;
//   in_ready returns the cycle after the result transfers out.
//   Reset clears the sequencer; no result is pending after reset.
// ----------------------------------------------------------------------------
module shell_integer_alu #(
  parameter int unsigned DATA_WIDTH = sia_pkg::DataWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sia_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sia_pkg::out_item_t out_data
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_MUL  = 6'b000010, S_DIV  = 6'b000100,
    S_PSQ  = 6'b001000, S_PMUL = 6'b010000, S_OUT  = 6'b100000
  } state_t;

  state_t        st_r, st_nxt;
  logic [4:0]    cmd_r, cmd_nxt;
  logic [W-1:0]  l_r, l_nxt, r_r, r_nxt;
  logic [W-1:0]  acc_r, acc_nxt;     // pow result / remainder
  logic [W-1:0]  q_r, q_nxt;         // quotient / pow exponent
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [63:0]   res_r, res_nxt;
  logic [1:0]    err_r, err_nxt;

  logic          m_start, m_done;
  logic [W-1:0]  m_a, m_b, m_p;

  sia_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .p(m_p)
  );

  logic [W-1:0] il, ir, simple, minw, sh_fill;
  logic [5:0]   cnt6;
  logic         lts, eqv;
  logic [W:0]   trial;
  logic [W-1:0] rem_sh;

  assign minw = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    il      = in_data.left_operand[W-1:0];
    ir      = in_data.right_operand[W-1:0];
    cnt6    = ir[5:0];
    lts     = $signed(il) < $signed(ir);
    eqv     = il == ir;
    sh_fill = {W{il[W-1]}};
    simple  = '0;
    case (in_data.command)
      sia_pkg::OP_ADD:  simple = il + ir;
      sia_pkg::OP_SUB:  simple = il - ir;
      sia_pkg::OP_SHL:  simple = (32'(cnt6) >= W) ? '0 : il << cnt6;
      sia_pkg::OP_SHR:  simple = (32'(cnt6) >= W) ? sh_fill
                                 : W'($signed(il) >>> cnt6);
      sia_pkg::OP_LT:   simple = W'(lts);
      sia_pkg::OP_LE:   simple = W'(lts | eqv);
      sia_pkg::OP_GT:   simple = W'(!(lts | eqv));
      sia_pkg::OP_GE:   simple = W'(!lts);
      sia_pkg::OP_EQ:   simple = W'(eqv);
      sia_pkg::OP_NE:   simple = W'(!eqv);
      sia_pkg::OP_AND:  simple = il & ir;
      sia_pkg::OP_XOR:  simple = il ^ ir;
      sia_pkg::OP_OR:   simple = il | ir;
      sia_pkg::OP_LAND: simple = W'((il != '0) && (ir != '0));
      sia_pkg::OP_LOR:  simple = W'((il != '0) || (ir != '0));
      sia_pkg::OP_NEG:  simple = '0 - il;
      sia_pkg::OP_LNOT: simple = W'(il == '0);
      sia_pkg::OP_BNOT: simple = ~il;
      default:          simple = '0;
    endcase
  end

  // one restoring divide step on magnitudes: remainder in acc_r, dividend in q_r
  always_comb begin
    rem_sh = {acc_r[W-2:0], q_r[W-1]};
    trial  = {1'b0, rem_sh} - {1'b0, r_r};
  end

  always_comb begin
    st_nxt   = st_r;
    cmd_nxt  = cmd_r;
    l_nxt    = l_r;
    r_nxt    = r_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    res_nxt  = res_r;
    err_nxt  = err_r;
    m_start  = 1'b0;
    m_a      = l_r;
    m_b      = r_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data.command;
          l_nxt   = il;
          r_nxt   = ir;
          err_nxt = sia_pkg::ERR_NONE;
          res_nxt = 64'($signed(simple));
          st_nxt  = S_OUT;
          case (in_data.command)
            sia_pkg::OP_MUL: begin
              m_start = 1'b1;
              m_a     = il;
              m_b     = ir;
              st_nxt  = S_MUL;
            end
            sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
              if (ir == '0) begin
                res_nxt = '0;
                err_nxt = sia_pkg::ERR_DIV0;
              end else if (il == minw && ir == '1) begin
                res_nxt = (in_data.command == sia_pkg::OP_DIV)
                          ? 64'($signed(minw)) : '0;
              end else begin
                // work on magnitudes; fix signs at the end
                qneg_nxt = il[W-1] ^ ir[W-1];
                rneg_nxt = il[W-1];
                q_nxt    = il[W-1] ? '0 - il : il;
                r_nxt    = ir[W-1] ? '0 - ir : ir;
                acc_nxt  = '0;
                cnt_nxt  = CW'(W);
                st_nxt   = S_DIV;
              end
            end
            sia_pkg::OP_POW: begin
              if (ir[W-1]) begin
                res_nxt = '0;
                err_nxt = sia_pkg::ERR_NEG_EXP;
              end else begin
                acc_nxt = W'(1);
                q_nxt   = ir;
                st_nxt  = S_PSQ;
                if (ir == '0) begin
                  res_nxt = 64'd1;
                  st_nxt  = S_OUT;
                end else if (ir[0]) begin
                  m_start = 1'b1;
                  m_a     = W'(1);
                  m_b     = il;
                  st_nxt  = S_PMUL;
                end else begin
                  m_start = 1'b1;
                  m_a     = il;
                  m_b     = il;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        if (m_done) begin
          res_nxt = 64'($signed(m_p));
          st_nxt  = S_OUT;
        end
      end
      S_DIV: begin
        if (!trial[W]) begin
          acc_nxt = trial[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          q_nxt   = {q_r[W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          st_nxt = S_OUT;
          if (cmd_r == sia_pkg::OP_DIV)
            res_nxt = 64'($signed(qneg_r ? '0 - q_nxt : q_nxt));
          else
            res_nxt = 64'($signed(rneg_r ? '0 - acc_nxt : acc_nxt));
        end
      end
      S_PMUL: begin
        // result times base finished; q_r[0] is the exponent bit just used
        if (m_done) begin
          acc_nxt = m_p;
          if ((q_r >> 1) == '0) begin
            res_nxt = 64'($signed(m_p));
            st_nxt  = S_OUT;
          end else begin
            m_start = 1'b1;
            m_a     = l_r;
            m_b     = l_r;
            st_nxt  = S_PSQ;
          end
        end
      end
      S_PSQ: begin
        // base squared; advance to its exponent bit, multiply it in when set
        if (m_done) begin
          l_nxt = m_p;
          q_nxt = q_r >> 1;
          if (q_nxt[0]) begin
            m_start = 1'b1;
            m_a     = acc_r;
            m_b     = m_p;
            st_nxt  = S_PMUL;
          end else begin
            m_start = 1'b1;
            m_a     = m_p;
            m_b     = m_p;
          end
        end
      end
      S_OUT: begin
        if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
    cmd_r  <= cmd_nxt;
    l_r    <= l_nxt;
    r_r    <= r_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
    res_r  <= res_nxt;
    err_r  <= err_nxt;
  end

  assign in_ready            = (st_r == S_IDLE);
  assign out_valid           = (st_r == S_OUT);
  assign out_data.result     = res_r;
  assign out_data.error_code = err_r;
endmodule

FILE: bench/tb_shell_integer_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_integer_alu: self-checking bench for the shell integer ALU
// A directed table walks every operation and the corner cases, then random
// operations follow. Each result is checked against the row's expected value or a
// local model of the ALU under random idle gaps on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_shell_integer_alu;

  localparam int          NumRandom   = 630;
  localparam longint      CycleLimit  = 1500000;
  localparam int          DrainCycles = 40;
  localparam int          HoldCycles  = 300;
  localparam int          HoldAtItem  = 150;
  localparam int          PauseAtItem = 350;
  localparam logic [4:0]  CmdFirstUnused = 5'd22;
  localparam logic [4:0]  CmdLast        = 5'd31;
  localparam logic signed [63:0] MinVal = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MaxVal = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    sia_pkg::in_item_t  stim;
    bit                 typed;
    sia_pkg::out_item_t want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  sia_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  sia_pkg::out_item_t out_data;

  // expectation that travels with the item on the input channel
  bit                 cur_typed;
  sia_pkg::out_item_t cur_want;

  row_t               dir_rows[$];
  sia_pkg::out_item_t pending_q[$];
  int                 err_count = 0;
  int                 sent_count = 0;
  longint             cycle_count = 0;

  shell_integer_alu i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic sia_pkg::out_item_t alu_compute(sia_pkg::in_item_t it);
    sia_pkg::out_item_t  o;
    logic signed [63:0]  l;
    logic signed [63:0]  r;
    logic signed [63:0]  base;
    logic        [63:0]  e;
    logic        [5:0]   cnt;
    l = it.left_operand;
    r = it.right_operand;
    cnt = r[5:0];
    o.result = '0;
    o.error_code = sia_pkg::ERR_NONE;
    case (it.command)
      sia_pkg::OP_ADD: o.result = l + r;
      sia_pkg::OP_SUB: o.result = l - r;
      sia_pkg::OP_MUL: o.result = l * r;
      sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
        if (r == 0) begin
          o.error_code = sia_pkg::ERR_DIV0;
        end else if (l == MinVal && r == -64'sd1) begin
          o.result = (it.command == sia_pkg::OP_DIV) ? MinVal : 64'sd0;
        end else begin
          o.result = (it.command == sia_pkg::OP_DIV) ? l / r : l % r;
        end
      end
      sia_pkg::OP_POW: begin
        if (r < 0) begin
          o.error_code = sia_pkg::ERR_NEG_EXP;
        end else begin
          base = l;
          e = r;
          o.result = 64'sd1;
          while (e != 0) begin
            if (e[0]) o.result = o.result * base;
            e = e >> 1;
            if (e != 0) base = base * base;
          end
        end
      end
      sia_pkg::OP_SHL:  o.result = l <<< cnt;
      sia_pkg::OP_SHR:  o.result = l >>> cnt;
      sia_pkg::OP_LT:   o.result = {63'd0, l < r};
      sia_pkg::OP_LE:   o.result = {63'd0, l <= r};
      sia_pkg::OP_GT:   o.result = {63'd0, l > r};
      sia_pkg::OP_GE:   o.result = {63'd0, l >= r};
      sia_pkg::OP_EQ:   o.result = {63'd0, l == r};
      sia_pkg::OP_NE:   o.result = {63'd0, l != r};
      sia_pkg::OP_AND:  o.result = l & r;
      sia_pkg::OP_XOR:  o.result = l ^ r;
      sia_pkg::OP_OR:   o.result = l | r;
      sia_pkg::OP_LAND: o.result = {63'd0, (l != 0) && (r != 0)};
      sia_pkg::OP_LOR:  o.result = {63'd0, (l != 0) || (r != 0)};
      sia_pkg::OP_NEG:  o.result = -l;
      sia_pkg::OP_LNOT: o.result = {63'd0, l == 0};
      sia_pkg::OP_BNOT: o.result = ~l;
      default: o.result = '0;
    endcase
    return o;
  endfunction

  task automatic add_row(logic [4:0] cmd, logic signed [63:0] l, logic signed [63:0] r,
                         bit typed, logic signed [63:0] res, sia_pkg::err_t err);
    row_t row;
    row.stim.command = cmd;
    row.stim.left_operand = l;
    row.stim.right_operand = r;
    row.typed = typed;
    row.want.result = res;
    row.want.error_code = err;
    dir_rows.push_back(row);
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MinVal;
      1: return MaxVal;
      2: return 64'sd0;
      3: return -64'sd1;
      4: return 64'sd1;
      5: return $signed(64'($urandom_range(0, 200))) - 64'sd100;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic sia_pkg::in_item_t random_item();
    sia_pkg::in_item_t it;
    it.command = ($urandom_range(0, 19) == 0)
                 ? 5'($urandom_range(CmdFirstUnused, CmdLast))
                 : 5'($urandom_range(sia_pkg::OP_ADD, sia_pkg::OP_BNOT));
    it.left_operand = pick_operand();
    it.right_operand = pick_operand();
    case (it.command)
      sia_pkg::OP_POW: begin
        // keep most exponents short; a full-width exponent is slow
        case ($urandom_range(0, 9))
          0: it.right_operand = -$signed(64'($urandom_range(1, 1000)));
          1: it.right_operand = {1'b1, $urandom, 31'($urandom)};
          2: if ($urandom_range(0, 3) == 0) it.right_operand = {1'b0, $urandom, 31'($urandom)};
          default: it.right_operand = 64'($urandom_range(0, 24));
        endcase
      end
      sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
        if ($urandom_range(0, 7) == 0) it.right_operand = 64'sd0;
        else if ($urandom_range(0, 7) == 0) begin
          it.left_operand = MinVal;
          it.right_operand = -64'sd1;
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  // put one item on the input channel and hold it until the transfer
  task automatic send_item(sia_pkg::in_item_t it, bit typed, sia_pkg::out_item_t want);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    cur_typed <= typed;
    cur_want  <= want;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cur_typed = 1'b0;
    cur_want  = '0;

    add_row(sia_pkg::OP_ADD,  MaxVal, 64'sd1, 1, MinVal, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_SUB,  MinVal, 64'sd1, 1, MaxVal, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_MUL,  MaxVal, MaxVal, 1, 64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_DIV,  64'sd7, 64'sd0, 1, 64'sd0, sia_pkg::ERR_DIV0);
    add_row(sia_pkg::OP_MOD,  MinVal, 64'sd0, 1, 64'sd0, sia_pkg::ERR_DIV0);
    add_row(sia_pkg::OP_DIV,  MinVal, -64'sd1, 1, MinVal, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_MOD,  MinVal, -64'sd1, 1, 64'sd0, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_DIV,  -64'sd7, 64'sd2, 0, '0, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_MOD,  -64'sd7, 64'sd2, 0, '0, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_POW,  64'sd3, -64'sd1, 1, 64'sd0, sia_pkg::ERR_NEG_EXP);
    add_row(sia_pkg::OP_POW,  64'sd0, 64'sd0, 1, 64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_POW,  -64'sd3, 64'sd41, 0, '0, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_POW,  -64'sd1, MaxVal, 1, -64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_SHL,  -64'sd1, 64'sd127, 1, MinVal, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_SHR,  MinVal, 64'sd63, 1, -64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_LT,   MinVal, MaxVal, 1, 64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_LE,   MaxVal, MaxVal, 1, 64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_GT,   -64'sd1, 64'sd0, 1, 64'sd0, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_GE,   MinVal, MinVal, 1, 64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_EQ,   MinVal, MaxVal, 0, '0, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_NE,   64'sd5, 64'sd5, 0, '0, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_AND,  -64'sd1, MinVal, 0, '0, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_XOR,  MaxVal, -64'sd1, 1, MinVal, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_OR,   MinVal, MaxVal, 1, -64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_LAND, 64'sd3, 64'sd0, 1, 64'sd0, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_LOR,  64'sd0, MinVal, 1, 64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_NEG,  MinVal, 64'sd9, 1, MinVal, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_LNOT, 64'sd0, -64'sd1, 1, 64'sd1, sia_pkg::ERR_NONE);
    add_row(sia_pkg::OP_BNOT, 64'sd0, 64'sd0, 1, -64'sd1, sia_pkg::ERR_NONE);
    add_row(CmdLast, -64'sd1, -64'sd1, 1, 64'sd0, sia_pkg::ERR_NONE);

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    for (int n = 0; n < NumRandom; n++) begin
      if (sent_count == PauseAtItem) begin
        // drain the block completely before going on
        in_valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(negedge clk);
      end
      send_item(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sent_count >= HoldAtItem) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (1 + gap_len()) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    sia_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_q.push_back(cur_typed ? cur_want : alu_compute(in_data));
      end
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = pending_q.pop_front();
          if (out_data.result !== want.result)
            report_mismatch($sformatf("result %h, expected %h", out_data.result, want.result));
          if (out_data.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      out_data.error_code, want.error_code));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

FILE: shell_integer_alu.f
hw/rtl/sia_pkg.sv
hw/rtl/sia_mul.sv
hw/rtl/shell_integer_alu.sv
bench/tb_shell_integer_alu.sv
